/* design/lmws_pkg.sv */
// shared constants, types and register codes for the local map window shift block
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package lmws_pkg;

  // default geometry
  localparam int COORD_BITS_DEF = 32;
  localparam int AXES_DEF       = 3;
  localparam int MAX_AXES       = 3;

  // configuration field widths
  localparam int CL_BITS   = 21;
  localparam int DR_BITS   = 21;
  localparam int MF_BITS   = 12;
  localparam int THR_BITS  = 25;
  localparam int MOV_BITS  = 25;
  localparam int HALF_BITS = 20;
  localparam int MOVA_BITS = 21;
  localparam int THRB_BITS = 20;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 21;

  // register reset values
  localparam logic [CL_BITS-1:0] CUBE_LENGTH_RST  = 21'd200000;
  localparam logic [DR_BITS-1:0] DETECT_RANGE_RST = 21'd300000;
  localparam logic [MF_BITS-1:0] MOVE_FACTOR_RST  = 12'd384;
  localparam logic [MF_BITS-1:0] MF_UNITY         = 12'd256;

  // reciprocal multipliers: floor(x/10) for x < 2^26, floor(x/5) for x < 2^23
  localparam logic [23:0] DIV10_MUL   = 24'd13421773;
  localparam int          DIV10_SHIFT = 27;
  localparam logic [22:0] DIV5_MUL    = 23'd6710887;
  localparam int          DIV5_SHIFT  = 25;

  // cycles for derived values to settle after a register write
  localparam int          STL_BITS      = 3;
  localparam logic [STL_BITS-1:0] SETTLE_CYCLES = 3'd5;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CUBE_LENGTH  = 2'd0,
    REG_DETECT_RANGE = 2'd1,
    REG_MOVE_FACTOR  = 2'd2
  } cfg_reg_t;

  // derived window parameters
  typedef struct packed {
    logic                 busy;
    logic [THR_BITS-1:0]  thr;
    logic [MOV_BITS-1:0]  mov;
    logic [CL_BITS-1:0]   cl;
    logic [HALF_BITS-1:0] half_lo;
    logic [CL_BITS-1:0]   half_hi;
  } prm_t;

  // per-item result control, evaluator to result buffer
  typedef struct packed {
    logic                load;
    logic [MAX_AXES-1:0] hit;
    logic [MAX_AXES-1:0] low;
  } rslt_ctl_t;

endpackage

`default_nettype wire

/* design/lmws_cfg_if.sv */
// configuration write channel: register index and write data
// depends on lmws_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lmws_cfg_if import lmws_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/lmws_in_if.sv */
// input channel: sensor position beat
// depends on lmws_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lmws_in_if import lmws_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

`default_nettype wire

/* design/lmws_out_if.sv */
// result channel: removed slab beat
// depends on lmws_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lmws_out_if import lmws_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] rm_min_x;
  logic signed [COORD_BITS-1:0] rm_min_y;
  logic signed [COORD_BITS-1:0] rm_min_z;
  logic signed [COORD_BITS-1:0] rm_max_x;
  logic signed [COORD_BITS-1:0] rm_max_y;
  logic signed [COORD_BITS-1:0] rm_max_z;
  logic                         last_box;

  modport source (output valid, output rm_min_x, output rm_min_y, output rm_min_z,
                  output rm_max_x, output rm_max_y, output rm_max_z, output last_box,
                  input ready);
  modport sink   (input valid, input rm_min_x, input rm_min_y, input rm_min_z,
                  input rm_max_x, input rm_max_y, input rm_max_z, input last_box,
                  output ready);
endinterface

`default_nettype wire

/* design/lmws_cfg.sv */
// configuration registers and the registered pipeline deriving threshold and move distance
// depends on lmws_pkg, lmws_cfg_if
`timescale 1ns / 1ps
`default_nettype none

module lmws_cfg import lmws_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lmws_cfg_if.sink   cfg_bus,
  output prm_t       prm
);

  logic [CL_BITS-1:0]   cl_r;
  logic [DR_BITS-1:0]   dr_r;
  logic [MF_BITS-1:0]   mf_r;
  logic [STL_BITS-1:0]  stl_cnt_r;

  logic [THR_BITS-1:0]  thr_a_r;
  logic [THRB_BITS-1:0] thr_b_r;
  logic [MOV_BITS-1:0]  mov_b_r;
  logic [HALF_BITS-1:0] half_lo_r;
  logic [CL_BITS-1:0]   half_hi_r;
  logic [THR_BITS-1:0]  thr_r;
  logic [22:0]          z_r;
  logic [MOVA_BITS-1:0] mov_a_r;
  logic [MOV_BITS-1:0]  mov_r;

  logic [MF_BITS+DR_BITS-1:0] prod_a;
  logic [MF_BITS+DR_BITS-1:0] prod_m;
  logic [MF_BITS-1:0]         mf_ex;
  logic [CL_BITS+1:0]         x3;
  logic [46:0]                prod_b;
  logic [CL_BITS:0]           y_w;
  logic [24:0]                y9;
  logic [45:0]                prod_z;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_r      <= CUBE_LENGTH_RST;
      dr_r      <= DETECT_RANGE_RST;
      mf_r      <= MOVE_FACTOR_RST;
      stl_cnt_r <= SETTLE_CYCLES;
    end else if (cfg_bus.valid) begin
      stl_cnt_r <= SETTLE_CYCLES;
      case (cfg_bus.index)
        REG_CUBE_LENGTH:  cl_r <= cfg_bus.data[CL_BITS-1:0];
        REG_DETECT_RANGE: dr_r <= cfg_bus.data[DR_BITS-1:0];
        REG_MOVE_FACTOR:  mf_r <= cfg_bus.data[MF_BITS-1:0];
        default: ;
      endcase
    end else if (stl_cnt_r != '0) begin
      stl_cnt_r <= stl_cnt_r - 1'b1;
    end
  end

  // stage 1: products
  always_comb begin
    mf_ex  = (mf_r > MF_UNITY) ? (mf_r - MF_UNITY) : '0;
    prod_a = {{DR_BITS{1'b0}}, mf_r} * {{MF_BITS{1'b0}}, dr_r};
    prod_m = {{DR_BITS{1'b0}}, mf_ex} * {{MF_BITS{1'b0}}, dr_r};
    x3     = {2'b00, cl_r} + {1'b0, cl_r, 1'b0};
    prod_b = {24'b0, x3} * {23'b0, DIV10_MUL};
  end

  // stage 3: cube_length - 2*thr, times 9, over 4
  always_comb begin
    y_w = {1'b0, cl_r} - {1'b0, thr_r[THRB_BITS-1:0], 1'b0};
    y9  = {1'b0, y_w[CL_BITS-1:0], 3'b000} + {4'b0000, y_w[CL_BITS-1:0]};
  end

  // stage 4: divide by 5
  assign prod_z = {23'b0, z_r} * {23'b0, DIV5_MUL};

  always_ff @(posedge clk) begin
    thr_a_r   <= prod_a[MF_BITS+DR_BITS-1:8];
    mov_b_r   <= prod_m[MF_BITS+DR_BITS-1:8];
    thr_b_r   <= prod_b[DIV10_SHIFT +: THRB_BITS];
    half_lo_r <= cl_r[CL_BITS-1:1];
    half_hi_r <= {1'b0, cl_r[CL_BITS-1:1]} + {{(CL_BITS-1){1'b0}}, cl_r[0]};
    thr_r     <= (thr_a_r < {{(THR_BITS-THRB_BITS){1'b0}}, thr_b_r}) ?
                 thr_a_r : {{(THR_BITS-THRB_BITS){1'b0}}, thr_b_r};
    z_r       <= y9[24:2];
    mov_a_r   <= prod_z[DIV5_SHIFT +: MOVA_BITS];
    mov_r     <= (mov_b_r > {{(MOV_BITS-MOVA_BITS){1'b0}}, mov_a_r}) ?
                 mov_b_r : {{(MOV_BITS-MOVA_BITS){1'b0}}, mov_a_r};
  end

  assign prm.busy    = (stl_cnt_r != '0);
  assign prm.thr     = thr_r;
  assign prm.mov     = mov_r;
  assign prm.cl      = cl_r;
  assign prm.half_lo = half_lo_r;
  assign prm.half_hi = half_hi_r;

endmodule

`default_nettype wire

/* design/lmws_box.sv */
// input register, local map box state and per-axis face check and shift
// depends on lmws_pkg, lmws_in_if
`timescale 1ns / 1ps
`default_nettype none

module lmws_box import lmws_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AXES       = AXES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  lmws_in_if.sink                              in_bus,
  input  prm_t                                 prm,
  input  logic                                 room,
  output rslt_ctl_t                            ctl,
  output logic [MAX_AXES-1:0][COORD_BITS-1:0]  old_lo,
  output logic [MAX_AXES-1:0][COORD_BITS-1:0]  old_hi,
  output logic [MAX_AXES-1:0][COORD_BITS-1:0]  rm_val
);

  localparam int EW = ((COORD_BITS > MOV_BITS) ? COORD_BITS : MOV_BITS) + 2;

  typedef logic signed [EW-1:0]         wide_t;
  typedef logic signed [COORD_BITS-1:0] crd_t;

  localparam wide_t CMAX_E = {{(EW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam wide_t CMIN_E = {{(EW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  function automatic crd_t sat_crd(input wide_t v);
    crd_t r;
    if (v > CMAX_E) begin
      r = CMAX_E[COORD_BITS-1:0];
    end else if (v < CMIN_E) begin
      r = CMIN_E[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic wide_t sx(input crd_t v);
    return {{(EW-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  crd_t                pos_all [MAX_AXES];
  logic                inv_r;
  logic                box_ready_r;
  logic                in_fire;
  logic                eval_fire;
  logic [MAX_AXES-1:0] hit;
  logic [MAX_AXES-1:0] low;
  wide_t               thr_e;
  wide_t               mov_e;
  wide_t               hlo_e;
  wide_t               hhi_e;
  crd_t                cl_min;

  assign pos_all[0] = in_bus.pos_x;
  assign pos_all[1] = in_bus.pos_y;
  assign pos_all[2] = in_bus.pos_z;

  assign thr_e  = {{(EW-THR_BITS){1'b0}}, prm.thr};
  assign mov_e  = {{(EW-MOV_BITS){1'b0}}, prm.mov};
  assign hlo_e  = {{(EW-HALF_BITS){1'b0}}, prm.half_lo};
  assign hhi_e  = {{(EW-CL_BITS){1'b0}}, prm.half_hi};
  // high face when the low face clamps at the bottom of the range
  assign cl_min = sat_crd(CMIN_E + {{(EW-CL_BITS){1'b0}}, prm.cl});

  assign eval_fire    = inv_r && ((hit == '0) || room);
  assign in_bus.ready = !prm.busy && (!inv_r || eval_fire);
  assign in_fire      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r       <= 1'b0;
      box_ready_r <= 1'b0;
    end else begin
      inv_r <= in_fire || (inv_r && !eval_fire);
      if (eval_fire) begin
        box_ready_r <= 1'b1;
      end
    end
  end

  for (genvar i = 0; i < MAX_AXES; i++) begin : g_lane
    if (i < AXES) begin : g_on
      crd_t  pos_r;
      crd_t  lo_r;
      crd_t  hi_r;
      crd_t  lo_nxt;
      crd_t  hi_nxt;
      wide_t pe;
      wide_t le;
      wide_t he;
      wide_t dl;
      wide_t dh;
      wide_t adl;
      wide_t adh;
      wide_t sl;
      crd_t  dn_lo;
      crd_t  dn_hi;
      crd_t  up_lo;
      crd_t  up_hi;
      crd_t  set_lo;
      crd_t  set_hi;
      logic  lside;
      logic  hside;

      assign pe  = sx(pos_r);
      assign le  = sx(lo_r);
      assign he  = sx(hi_r);
      assign dl  = pe - le;
      assign dh  = pe - he;
      assign adl = dl[EW-1] ? -dl : dl;
      assign adh = dh[EW-1] ? -dh : dh;
      assign lside = (adl <= thr_e);
      assign hside = (adh <= thr_e);

      assign dn_lo = sat_crd(le - mov_e);
      assign dn_hi = sat_crd(he - mov_e);
      assign up_lo = sat_crd(le + mov_e);
      assign up_hi = sat_crd(he + mov_e);

      // first position: centre the box on the sensor
      assign sl     = pe - hlo_e;
      assign set_lo = sat_crd(sl);
      assign set_hi = (sl < CMIN_E) ? cl_min : sat_crd(pe + hhi_e);

      always_comb begin
        lo_nxt = lo_r;
        hi_nxt = hi_r;
        if (!box_ready_r) begin
          lo_nxt = set_lo;
          hi_nxt = set_hi;
        end else if (lside) begin
          lo_nxt = dn_lo;
          hi_nxt = dn_hi;
        end else if (hside) begin
          lo_nxt = up_lo;
          hi_nxt = up_hi;
        end
      end

      always_ff @(posedge clk) begin
        if (in_fire) begin
          pos_r <= pos_all[i];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          lo_r <= '0;
          hi_r <= '0;
        end else if (eval_fire) begin
          lo_r <= lo_nxt;
          hi_r <= hi_nxt;
        end
      end

      assign hit[i]    = box_ready_r && (lside || hside);
      assign low[i]    = lside;
      assign old_lo[i] = lo_r;
      assign old_hi[i] = hi_r;
      assign rm_val[i] = lside ? dn_hi : up_lo;
    end else begin : g_off
      assign hit[i]    = 1'b0;
      assign low[i]    = 1'b0;
      assign old_lo[i] = '0;
      assign old_hi[i] = '0;
      assign rm_val[i] = '0;
    end
  end

  assign ctl.load = eval_fire && (hit != '0);
  assign ctl.hit  = hit;
  assign ctl.low  = low;

  a_no_slab_before_setup: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> box_ready_r)
    else $error("slab emitted before the box was set up");

  a_setup_once: assert property (@(posedge clk) disable iff (!rst_n)
    (eval_fire && !box_ready_r) |=> box_ready_r)
    else $error("box not marked ready after setup position");

endmodule

`default_nettype wire

/* design/lmws_rbuf.sv */
// result buffer: packs one position's removed slabs, drained one beat a cycle while ready
// depends on lmws_pkg, lmws_out_if
`timescale 1ns / 1ps
`default_nettype none

module lmws_rbuf import lmws_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AXES       = AXES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rslt_ctl_t                            ctl,
  input  logic [MAX_AXES-1:0][COORD_BITS-1:0]  old_lo,
  input  logic [MAX_AXES-1:0][COORD_BITS-1:0]  old_hi,
  input  logic [MAX_AXES-1:0][COORD_BITS-1:0]  rm_val,
  output logic                                 room,
  lmws_out_if.source                           out_bus
);

  localparam int CNT_BITS = $clog2(AXES + 1);
  localparam int IDX_BITS = (AXES > 1) ? $clog2(AXES) : 1;

  typedef struct packed {
    logic [MAX_AXES-1:0][COORD_BITS-1:0] mn;
    logic [MAX_AXES-1:0][COORD_BITS-1:0] mx;
    logic                                last;
  } slab_t;

  slab_t               ent_r   [AXES];
  slab_t               ent_nxt [AXES];
  slab_t               ld_ent  [AXES];
  slab_t               cand    [MAX_AXES];
  logic [CNT_BITS-1:0] cnt_r;
  logic [CNT_BITS-1:0] cnt_nxt;
  logic [CNT_BITS-1:0] ld_cnt;
  logic                out_fire;

  assign out_fire = out_bus.valid && out_bus.ready;
  assign room     = (cnt_r == '0) || ((cnt_r == CNT_BITS'(1)) && out_bus.ready);

  // slab per shifted axis: old box with its own axis cut at the moved face
  always_comb begin
    for (int i = 0; i < MAX_AXES; i++) begin
      cand[i].mn   = old_lo;
      cand[i].mx   = old_hi;
      if (ctl.low[i]) begin
        cand[i].mn[i] = rm_val[i];
      end else begin
        cand[i].mx[i] = rm_val[i];
      end
      cand[i].last = ctl.hit[i] && ((ctl.hit >> (i + 1)) == '0);
    end
  end

  // pack shifted axes in x, y, z order
  always_comb begin : p_pack
    logic [CNT_BITS-1:0] slot;
    slot = '0;
    for (int k = 0; k < AXES; k++) begin
      ld_ent[k] = '0;
    end
    for (int i = 0; i < AXES; i++) begin
      if (ctl.hit[i]) begin
        ld_ent[slot[IDX_BITS-1:0]] = cand[i];
        slot = slot + 1'b1;
      end
    end
    ld_cnt = slot;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ent_nxt = ent_r;
    if (ctl.load) begin
      cnt_nxt = ld_cnt;
      ent_nxt = ld_ent;
    end else if (out_fire) begin
      cnt_nxt = cnt_r - 1'b1;
      for (int k = 0; k < AXES - 1; k++) begin
        ent_nxt[k] = ent_r[k + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign out_bus.valid    = (cnt_r != '0);
  assign out_bus.rm_min_x = ent_r[0].mn[0];
  assign out_bus.rm_min_y = ent_r[0].mn[1];
  assign out_bus.rm_min_z = ent_r[0].mn[2];
  assign out_bus.rm_max_x = ent_r[0].mx[0];
  assign out_bus.rm_max_y = ent_r[0].mx[1];
  assign out_bus.rm_max_z = ent_r[0].mx[2];
  assign out_bus.last_box = ent_r[0].last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_BITS'(AXES))
    else $error("result buffer count beyond depth");

  a_tail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_BITS'(1)) |-> ent_r[0].last)
    else $error("final pending slab not marked last");

  a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> room)
    else $error("slabs loaded over undelivered beats");

endmodule

`default_nettype wire

/* design/local_map_window_shift.sv */
// a position beat is registered at the input, and its removed slabs in the result buffer
// throughput: one position beat per cycle while the input is not stalled; a position
//   shifting n axes (up to 3) holds the result side for n beats, and only positions that
//   shift nothing pass it meanwhile; after reset and each configuration write the input
//   stays stalled while the threshold and move distance pipeline settles
// reset (rst_n low, synchronous): box cleared and marked not set up, registers to defaults
`timescale 1ns / 1ps
`default_nettype none

module local_map_window_shift import lmws_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AXES       = AXES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lmws_cfg_if.sink    cfg_bus,
  lmws_in_if.sink     in_bus,
  lmws_out_if.source  out_bus
);

  // derived window parameters: threshold, move distance and half edge lengths
  prm_t      prm;
  // per-position result control from the box evaluator
  rslt_ctl_t ctl;
  // buffer can accept a new set of slabs this cycle
  logic      room;

  // old box and moved face per axis, composed into slabs in the buffer
  logic [MAX_AXES-1:0][COORD_BITS-1:0] old_lo;
  logic [MAX_AXES-1:0][COORD_BITS-1:0] old_hi;
  logic [MAX_AXES-1:0][COORD_BITS-1:0] rm_val;

  // register file plus a five-stage pipeline (two multiplies by reciprocals)
  lmws_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .prm     (prm)
  );

  // input register and box state; face check, shift and saturation are combinational
  // the box updates on the same edge the slabs enter the buffer, so the next
  // position sees the moved box without a bubble
  lmws_box #(
    .COORD_BITS (COORD_BITS),
    .AXES       (AXES)
  ) u_box (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .prm    (prm),
    .room   (room),
    .ctl    (ctl),
    .old_lo (old_lo),
    .old_hi (old_hi),
    .rm_val (rm_val)
  );

  // up to AXES slab entries, drained one beat a cycle while the sink is ready, in x, y, z order
  lmws_rbuf #(
    .COORD_BITS (COORD_BITS),
    .AXES       (AXES)
  ) u_rbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .old_lo  (old_lo),
    .old_hi  (old_hi),
    .rm_val  (rm_val),
    .room    (room),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire
